FILE: design/sha256_block_compressor_assert.svh
// Assertion macros shared by the SHA-256 compressor modules.
`ifndef SHA256_BLOCK_COMPRESSOR_ASSERT_SVH
`define SHA256_BLOCK_COMPRESSOR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SHAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define SHAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/shac_pkg.sv
// Types, constants and round functions shared by the SHA-256 compressor.
`timescale 1ns / 1ps

package shac_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] hash_t;

    // One message request: a big-endian word plus start and end marks.
    typedef struct packed {
        logic [31:0] message_word;
        logic        message_start;
        logic        message_end;
    } msg_t;

    // One digest request.
    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } digest_t;

    // Commands from the block controller to the round engine.
    typedef struct packed {
        logic load;
        logic reload;
        logic begin_rounds;
    } shac_cmd_t;

    // Round engine status.
    typedef struct packed {
        logic idle;
    } shac_status_t;

    localparam int WORDS_PER_BLOCK = 16;
    localparam int HASH_WORDS      = 8;
    localparam int ROUNDS          = 64;

    localparam word_t INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rot_mix_a(input word_t x);
        rot_mix_a = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t rot_mix_e(input word_t x);
        rot_mix_e = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t sched_mix_far(input word_t x);
        sched_mix_far = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t sched_mix_near(input word_t x);
        sched_mix_near = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        choose = (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        majority = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

FILE: design/shac_core.sv
// SHA-256 round engine: schedule window, working variables, chaining value.
`timescale 1ns / 1ps
`include "sha256_block_compressor_assert.svh"

module shac_core
    import shac_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  shac_cmd_t    cmd,
    input  word_t        word,
    output shac_status_t status,
    output hash_t        chain
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD
    } core_state_t;

    core_state_t state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    hash_t       wv_reg, wv_next;
    hash_t       cv_reg, cv_next;
    word_t       win_reg [WORDS_PER_BLOCK];

    word_t sched_new;
    word_t shift_in;
    logic  shift_en;
    word_t t1;
    word_t t2;

    // Extend the schedule by one word from the fixed window taps.
    assign sched_new = sched_mix_near(win_reg[14]) + win_reg[9]
                     + sched_mix_far(win_reg[1]) + win_reg[0];

    assign shift_en = cmd.load | (state_reg == C_ROUND);
    assign shift_in = cmd.load ? word : sched_new;

    // One compression round on the working variables.
    assign t1 = wv_reg[7] + rot_mix_e(wv_reg[4]) + choose(wv_reg[4], wv_reg[5], wv_reg[6])
              + ROUND_K[round_reg] + win_reg[0];
    assign t2 = rot_mix_a(wv_reg[0]) + majority(wv_reg[0], wv_reg[1], wv_reg[2]);

    // Sequence: reload initial hash on request, copy chain, run rounds, fold back into chain.
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        wv_next    = wv_reg;
        cv_next    = cv_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (cmd.reload)
                begin
                    for (int i = 0; i < HASH_WORDS; i++)
                    begin
                        cv_next[i] = INIT_HASH[i];
                    end
                end
                if (cmd.begin_rounds)
                begin
                    wv_next    = cv_reg;
                    round_next = '0;
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                wv_next[7] = wv_reg[6];
                wv_next[6] = wv_reg[5];
                wv_next[5] = wv_reg[4];
                wv_next[4] = wv_reg[3] + t1;
                wv_next[3] = wv_reg[2];
                wv_next[2] = wv_reg[1];
                wv_next[1] = wv_reg[0];
                wv_next[0] = t1 + t2;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'(ROUNDS - 1))
                begin
                    state_next = C_ADD;
                end
            end
            C_ADD:
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    cv_next[i] = cv_reg[i] + wv_reg[i];
                end
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // Hold sequencer state, working variables and chaining value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            wv_reg    <= '0;
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                cv_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            wv_reg    <= wv_next;
            cv_reg    <= cv_next;
        end
    end

    // Advance the rolling schedule window; oldest word sits at the bottom.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < WORDS_PER_BLOCK - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[WORDS_PER_BLOCK - 1] <= shift_in;
        end
    end

    assign status.idle = (state_reg == C_IDLE);
    assign chain       = cv_reg;

    `SHAC_ASSERT_NOW(a_begin_when_idle, cmd.begin_rounds || cmd.load,
        state_reg == C_IDLE, "round engine commanded while busy")
    `SHAC_ASSERT_NEXT(a_last_round_adds,
        (state_reg == C_ROUND) && (round_reg == 6'(ROUNDS - 1)),
        state_reg == C_ADD, "last round not followed by chain add")
    `SHAC_ASSERT_NEXT(a_add_returns_idle, state_reg == C_ADD,
        (state_reg == C_IDLE) && $stable(round_reg), "chain add not followed by idle")

endmodule

FILE: design/sha256_block_compressor.sv
// SHA-256 block compressor top level: word intake, block sequencing, digest output.
// Feed a padded message as big-endian 32-bit words, sixteen per 512-bit block; mark
// the first word of a message with message_start and the words of its final block
// with message_end (only the sixteenth word's mark counts). After the sixteenth word
// the round engine runs the 64 rounds at one round per cycle and then adds into the
// chaining value, while msg_stall stays high. After a final block the eight digest
// words leave one per cycle while digest_stall is low, word 0 first, with digest_last
// on the eighth; intake resumes once the eighth is taken.
`timescale 1ns / 1ps
`include "sha256_block_compressor_assert.svh"

module sha256_block_compressor
    import shac_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    msg_valid,
    output logic    msg_stall,
    input  msg_t    msg,
    output logic    digest_valid,
    input  logic    digest_stall,
    output digest_t digest
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_WAIT,
        S_EMIT
    } top_state_t;

    top_state_t   state_reg, state_next;
    logic [3:0]   word_cnt_reg, word_cnt_next;
    logic         end_reg, end_next;
    logic         out_valid_reg, out_valid_next;
    digest_t      out_data_reg, out_data_next;
    logic [2:0]   idx_reg, idx_next;

    shac_cmd_t    cmd;
    shac_status_t core_status;
    hash_t        chain;
    logic         msg_take;
    logic         digest_take;
    logic [3:0]   word_pos;
    logic [2:0]   idx_inc;

    assign msg_stall   = (state_reg != S_LOAD);
    assign msg_take    = msg_valid & ~msg_stall;
    assign digest_take = out_valid_reg & ~digest_stall;

    // A start mark drops any partial block and restarts the count.
    assign word_pos = msg.message_start ? 4'd0 : word_cnt_reg;
    assign idx_inc  = idx_reg + 3'd1;

    assign cmd.load         = msg_take;
    assign cmd.reload       = msg_take & msg.message_start;
    assign cmd.begin_rounds = msg_take & (word_pos == 4'(WORDS_PER_BLOCK - 1));

    shac_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .word   (msg.message_word),
        .status (core_status),
        .chain  (chain)
    );

    // Sequence intake, compression wait and digest output.
    always_comb
    begin
        state_next     = state_reg;
        word_cnt_next  = word_cnt_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        idx_next       = idx_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (msg_take)
                begin
                    word_cnt_next = word_pos + 4'd1;
                    if (cmd.begin_rounds)
                    begin
                        end_next   = msg.message_end;
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                if (core_status.idle)
                begin
                    if (end_reg)
                    begin
                        out_valid_next            = 1'b1;
                        out_data_next.digest_word = chain[0];
                        out_data_next.digest_last = 1'b0;
                        idx_next                  = '0;
                        state_next                = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_EMIT:
            begin
                if (digest_take)
                begin
                    if (idx_reg == 3'(HASH_WORDS - 1))
                    begin
                        out_valid_next = 1'b0;
                        state_next     = S_LOAD;
                    end
                    else
                    begin
                        idx_next                  = idx_inc;
                        out_data_next.digest_word = chain[idx_inc];
                        out_data_next.digest_last = (idx_inc == 3'(HASH_WORDS - 1));
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Hold state and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            word_cnt_reg  <= '0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            word_cnt_reg  <= word_cnt_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            idx_reg       <= idx_next;
        end
    end

    assign digest_valid = out_valid_reg;
    assign digest       = out_data_reg;

    `SHAC_ASSERT_NOW(a_take_only_when_core_idle, msg_take, core_status.idle, "word accepted while rounds run")
    `SHAC_ASSERT_NOW(a_last_flag_matches_index, out_valid_reg, out_data_reg.digest_last == (idx_reg == 3'(HASH_WORDS - 1)), "digest last flag out of step")
    `SHAC_ASSERT_NEXT(a_last_taken_ends_burst, digest_take && out_data_reg.digest_last, !out_valid_reg && (state_reg == S_LOAD), "digest burst did not end after last word")

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the SHA-256 block compressor, with its own digest predictor.
`timescale 1ns / 1ps

module testbench;
    import shac_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 700;
    localparam int HOLD_AFTER   = 1500;
    localparam int DRAIN_CYCLES = 100;

    // SHA-256 initial hash and round constants, kept separately from the design
    localparam word_t IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_CONST_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    msg_valid    = 1'b0;
    logic    msg_stall;
    msg_t    msg          = '0;
    logic    digest_valid;
    logic    digest_stall = 1'b0;
    digest_t digest;

    // Stimulus and expectation stores
    msg_t    pending_words [$];
    digest_t expected_digest [$];

    // Predictor state: chaining value, schedule window, word position in block
    word_t      chain_value [8];
    word_t      sched_window [16];
    logic [3:0] block_pos;

    int   send_gap_left;
    int   recv_wait_left;
    int   hold_left;
    logic hold_done;
    int   cycle_count;
    int   words_accepted;
    int   blocks_folded;
    int   digests_predicted;
    int   results_checked;
    int   failures;

    sha256_block_compressor DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_stall    (msg_stall),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    // Free-running clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run the 64 rounds over the schedule window and add into the chaining value
    task automatic fold_block_into_chain();
        word_t a, b, c, d, e, f, g, h;
        word_t t1, t2, s0, s1, wt;
        int    r;
        a = chain_value[0]; b = chain_value[1]; c = chain_value[2]; d = chain_value[3];
        e = chain_value[4]; f = chain_value[5]; g = chain_value[6]; h = chain_value[7];
        for (r = 0; r < 64; r++)
        begin
            if (r >= 16)
            begin
                s0 = rotr(sched_window[(r - 15) % 16], 7)
                     ^ rotr(sched_window[(r - 15) % 16], 18)
                     ^ (sched_window[(r - 15) % 16] >> 3);
                s1 = rotr(sched_window[(r - 2) % 16], 17)
                     ^ rotr(sched_window[(r - 2) % 16], 19)
                     ^ (sched_window[(r - 2) % 16] >> 10);
                sched_window[r % 16] = s1 + sched_window[(r - 7) % 16] + s0
                                       + sched_window[r % 16];
            end
            wt = sched_window[r % 16];
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_CONST_TABLE[r] + wt;
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_value[0] += a; chain_value[1] += b; chain_value[2] += c; chain_value[3] += d;
        chain_value[4] += e; chain_value[5] += f; chain_value[6] += g; chain_value[7] += h;
        blocks_folded++;
    endtask

    // Take one accepted word into the predictor; queue a digest after a final block
    task automatic absorb_message_word(input msg_t item);
        digest_t d;
        int      i;
        if (item.message_start)
        begin
            foreach (chain_value[i])
                chain_value[i] = IV_WORDS[i];
            block_pos = '0;
        end
        sched_window[block_pos] = item.message_word;
        if (block_pos != 4'd15)
        begin
            block_pos = block_pos + 4'd1;
        end
        else
        begin
            block_pos = '0;
            fold_block_into_chain();
            if (item.message_end)
            begin
                for (i = 0; i < 8; i++)
                begin
                    d.digest_word = chain_value[i];
                    d.digest_last = (i == 7);
                    expected_digest.push_back(d);
                end
                digests_predicted++;
            end
        end
    endtask

    task automatic queue_word(input word_t w, input logic s, input logic e);
        msg_t item;
        item.message_word  = w;
        item.message_start = s;
        item.message_end   = e;
        pending_words.push_back(item);
    endtask

    function automatic word_t pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h00000000;
            1:       return 32'hffffffff;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Idle stretches come in bursts, with calm windows that never idle
    function automatic int pick_send_gap();
        if ((words_accepted / 48) % 3 == 1 || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    function automatic int pick_recv_wait();
        if ((results_checked / 16) % 3 == 1 || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d words and %0d digest words pending",
                     cycle_count, pending_words.size(), expected_digest.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Driver: offer requests from the pending queue, idling between them
    always @(posedge clk)
    begin : drive_requests
        logic offer;
        int   gap;
        msg_t next_item;
        if (!rst_n)
        begin
            msg_valid     <= 1'b0;
            send_gap_left <= 0;
        end
        else
        begin
            offer     = msg_valid;
            gap       = send_gap_left;
            next_item = msg;
            if (msg_valid && !msg_stall)
            begin
                absorb_message_word(msg);
                words_accepted++;
                offer = 1'b0;
                gap   = pick_send_gap();
            end
            if (!offer)
            begin
                if (gap == 0 && pending_words.size() != 0)
                begin
                    next_item = pending_words.pop_front();
                    offer     = 1'b1;
                end
                else if (gap != 0)
                begin
                    gap = gap - 1;
                end
            end
            msg_valid     <= offer;
            msg           <= next_item;
            send_gap_left <= gap;
        end
    end

    // Long output hold-off, once, while the sender keeps offering
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && digest_valid && cycle_count >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compare each digest request with the oldest expectation
    always @(posedge clk)
    begin : check_digests
        int      wait_left;
        digest_t want;
        if (!rst_n)
        begin
            digest_stall   <= 1'b0;
            recv_wait_left <= 0;
        end
        else
        begin
            wait_left = recv_wait_left;
            if (digest_valid && !digest_stall)
            begin
                if (expected_digest.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("Unexpected digest word %h last %b at cycle %0d",
                                 digest.digest_word, digest.digest_last, cycle_count);
                end
                else
                begin
                    want = expected_digest.pop_front();
                    if (digest.digest_word !== want.digest_word
                        || digest.digest_last !== want.digest_last)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display({"Digest mismatch at cycle %0d: ",
                                      "expected %h last %b, got %h last %b"},
                                     cycle_count, want.digest_word, want.digest_last,
                                     digest.digest_word, digest.digest_last);
                    end
                end
                results_checked++;
                wait_left = pick_recv_wait();
            end
            else if (wait_left != 0)
            begin
                wait_left = wait_left - 1;
            end
            recv_wait_left <= wait_left;
            digest_stall   <= (wait_left != 0) || (hold_left != 0);
        end
    end

    // Stimulus, reset and end of run
    initial
    begin : run_test
        int kind, nblk, len, b, i, finals;
        logic e;
        foreach (chain_value[i])
            chain_value[i] = IV_WORDS[i];
        foreach (sched_window[i])
            sched_window[i] = '0;
        block_pos         = '0;
        cycle_count       = 0;
        words_accepted    = 0;
        blocks_folded     = 0;
        digests_predicted = 0;
        results_checked   = 0;
        failures          = 0;
        finals            = 0;

        // Stray words with ignored end marks, then a start mark mid-block drops them
        queue_word(32'h00000000, 1'b0, 1'b1);
        queue_word(32'hffffffff, 1'b0, 1'b1);
        queue_word(32'h80000001, 1'b0, 1'b0);
        // Padded "abc" as one final block, with a stray end mark on its second word
        queue_word(32'h61626380, 1'b1, 1'b0);
        queue_word(32'h00000000, 1'b0, 1'b1);
        for (i = 2; i < 15; i++)
            queue_word(32'h00000000, 1'b0, 1'b0);
        queue_word(32'h00000018, 1'b0, 1'b1);

        // Random part: mostly whole messages, some chained blocks and broken blocks
        while (pending_words.size() < 380 || finals < 16)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                len = $urandom_range(1, 15);
                for (i = 0; i < len; i++)
                    queue_word(pick_word(), (i == 0) ? 1'($urandom_range(0, 1)) : 1'b0,
                               1'($urandom_range(0, 1)));
            end
            else if (kind == 1)
            begin
                // Continue from the current chaining value without a start mark
                for (i = 0; i < 16; i++)
                    queue_word(pick_word(), 1'b0,
                               (i == 15) ? 1'b1 : 1'($urandom_range(0, 1)));
                finals++;
            end
            else
            begin
                nblk = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
                for (b = 0; b < nblk; b++)
                begin
                    for (i = 0; i < 16; i++)
                    begin
                        if (i == 15)
                            e = (b == nblk - 1);
                        else
                            e = 1'($urandom_range(0, 1));
                        queue_word(pick_word(), (b == 0 && i == 0), e);
                    end
                end
                finals++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all words taken and every digest seen, then a quiet tail
        @(negedge clk);
        while (pending_words.size() != 0 || msg_valid || expected_digest.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d message words covering %0d blocks; checked %0d digest words of %0d digests.",
                 words_accepted, blocks_folded, results_checked, digests_predicted);
        $display("Output was held off once for %0d cycles while input kept arriving; %0d failures.",
                 HOLD_CYCLES, failures);
        if (failures == 0 && expected_digest.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
